>>> hdl/wbmp_sd_pkg.sv
// Shared types, codes and defaults for the WBMP stream decoder.
// Used by every module of the decoder; depends on nothing.

package wbmp_sd_pkg;

	localparam int DIM_BITS_DEF         = 16;
	localparam int MAX_VARINT_BYTES_DEF = 5;
	localparam int CMDQ_DEPTH_DEF       = 4;
	localparam int OUT_DIM_W            = 16;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic ERR_HDR_BYTE = 1'b0;
	localparam logic ERR_DIM      = 1'b1;

	localparam logic [7:0] PIX_WHITE = 8'hFF;
	localparam logic [7:0] PIX_BLACK = 8'h00;

	// One classified byte, as handed from the front to the back.
	typedef struct packed {
		logic [1:0]           kind;
		logic                 err;
		logic [7:0]           data;
		logic [OUT_DIM_W-1:0] w;
		logic [OUT_DIM_W-1:0] h;
		logic [2:0]           last_idx;  // index of the final pixel of the byte
		logic                 rend;      // final pixel closes a row
		logic                 iend;      // final pixel closes the image
	} cmd_t;

endpackage

>>> hdl/wbmp_sd_front.sv
// Front end of the WBMP stream decoder: header parsing, dimension checks and
// row bookkeeping; emits one command per byte that yields results.
// Depends on wbmp_sd_pkg.

module wbmp_sd_front #(
	parameter int DIM_BITS         = wbmp_sd_pkg::DIM_BITS_DEF,
	parameter int MAX_VARINT_BYTES = wbmp_sd_pkg::MAX_VARINT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_acc,
	input  logic [7:0]         in_byte,
	output logic               cmd_push,
	output wbmp_sd_pkg::cmd_t  cmd
);

	localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);
	localparam int OW    = wbmp_sd_pkg::OUT_DIM_W;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_WID,
		PH_HGT,
		PH_DATA
	} phase_t;

	phase_t              phase_q;
	logic [DIM_BITS-1:0] acc_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIM_BITS-1:0] width_q;
	logic                wovf_q;
	logic [DIM_BITS-1:0] height_q;
	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;

	logic [DIM_BITS+6:0] shifted;
	logic [DIM_BITS-1:0] acc_next;
	logic                ovf_next;
	logic [CNT_W-1:0]    cnt_next;
	logic                vdone;
	logic                dim_bad;
	logic [DIM_BITS-1:0] rem;
	logic [DIM_BITS-1:0] rem_m1;
	logic                rend;
	logic [DIM_BITS:0]   row_p1;
	logic                iend;
	logic [OW-1:0]       w_out;
	logic [OW-1:0]       h_out;

	// Anything shifted past DIM_BITS makes the value too large for good.
	assign shifted  = {acc_q, in_byte[6:0]};
	assign acc_next = shifted[DIM_BITS-1:0];
	assign ovf_next = ovf_q | (|shifted[DIM_BITS+6:DIM_BITS]);
	assign cnt_next = cnt_q + CNT_W'(1);
	assign vdone    = !in_byte[7] || (cnt_next >= CNT_W'(MAX_VARINT_BYTES));
	assign dim_bad  = wovf_q || (width_q == '0) || ovf_next || (acc_next == '0);

	assign rem    = width_q - col_q;
	assign rem_m1 = rem - DIM_BITS'(1);
	assign rend   = rem <= DIM_BITS'(8);
	assign row_p1 = {1'b0, row_q} + (DIM_BITS+1)'(1);
	assign iend   = rend && (row_p1 >= {1'b0, height_q});

	generate
		if (DIM_BITS >= OW) begin : g_trunc
			assign w_out = width_q[OW-1:0];
			assign h_out = acc_next[OW-1:0];
		end else begin : g_ext
			assign w_out = {{(OW-DIM_BITS){1'b0}}, width_q};
			assign h_out = {{(OW-DIM_BITS){1'b0}}, acc_next};
		end
	endgenerate

	always_comb begin
		cmd          = '0;
		cmd.kind     = wbmp_sd_pkg::KIND_PIXEL;
		cmd.data     = in_byte;
		cmd.last_idx = rend ? rem_m1[2:0] : 3'd7;
		cmd.rend     = rend;
		cmd.iend     = iend;
		cmd_push     = 1'b0;
		case (phase_q)
			PH_HDR0, PH_HDR1: begin
				cmd.kind = wbmp_sd_pkg::KIND_ERROR;
				cmd.err  = wbmp_sd_pkg::ERR_HDR_BYTE;
				cmd_push = in_acc && (in_byte != 8'h00);
			end
			PH_HGT: begin
				if (dim_bad) begin
					cmd.kind = wbmp_sd_pkg::KIND_ERROR;
					cmd.err  = wbmp_sd_pkg::ERR_DIM;
				end else begin
					cmd.kind = wbmp_sd_pkg::KIND_HEADER;
					cmd.w    = w_out;
					cmd.h    = h_out;
				end
				cmd_push = in_acc && vdone;
			end
			PH_DATA: begin
				cmd_push = in_acc;
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			width_q  <= '0;
			wovf_q   <= 1'b0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (in_acc) begin
			case (phase_q)
				PH_HDR0: begin
					phase_q <= (in_byte != 8'h00) ? PH_HDR0 : PH_HDR1;
				end
				PH_HDR1: begin
					if (in_byte != 8'h00) begin
						phase_q <= PH_HDR0;
					end else begin
						phase_q <= PH_WID;
						acc_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
					end
				end
				PH_WID: begin
					if (vdone) begin
						width_q <= acc_next;
						wovf_q  <= ovf_next;
						acc_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						phase_q <= PH_HGT;
					end else begin
						acc_q <= acc_next;
						ovf_q <= ovf_next;
						cnt_q <= cnt_next;
					end
				end
				PH_HGT: begin
					if (vdone) begin
						height_q <= acc_next;
						acc_q    <= '0;
						ovf_q    <= 1'b0;
						cnt_q    <= '0;
						col_q    <= '0;
						row_q    <= '0;
						phase_q  <= dim_bad ? PH_HDR0 : PH_DATA;
					end else begin
						acc_q <= acc_next;
						ovf_q <= ovf_next;
						cnt_q <= cnt_next;
					end
				end
				PH_DATA: begin
					if (iend) begin
						col_q   <= '0;
						row_q   <= '0;
						phase_q <= PH_HDR0;
					end else if (rend) begin
						col_q <= '0;
						row_q <= row_p1[DIM_BITS-1:0];
					end else begin
						col_q <= col_q + DIM_BITS'(8);
					end
				end
				default: begin
					phase_q <= PH_HDR0;
					acc_q   <= '0;
					ovf_q   <= 1'b0;
					cnt_q   <= '0;
					width_q <= '0;
					wovf_q  <= 1'b0;
					height_q <= '0;
					col_q   <= '0;
					row_q   <= '0;
				end
			endcase
		end
	end

	// While pixels are streaming the column always lies inside the row.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (col_q < width_q))
		else $error("column ran past the image width");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_VARINT_BYTES))
		else $error("dimension byte count went past its limit");

endmodule

>>> hdl/wbmp_sd_cmdq.sv
// Short command queue between the front and back of the WBMP decoder.
// Depends on wbmp_sd_pkg for the command type.

module wbmp_sd_cmdq #(
	parameter int DEPTH = wbmp_sd_pkg::CMDQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wbmp_sd_pkg::cmd_t wr_cmd,
	output logic              full,
	input  logic              pop,
	output wbmp_sd_pkg::cmd_t rd_cmd,
	output logic              empty
);

	localparam int AW = $clog2(DEPTH);

	wbmp_sd_pkg::cmd_t mem_q [DEPTH];
	logic [AW:0]       wr_ptr_q;
	logic [AW:0]       rd_ptr_q;

	assign empty  = (wr_ptr_q == rd_ptr_q);
	assign full   = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign rd_cmd = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command written into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command read from an empty queue");

endmodule

>>> hdl/wbmp_sd_back.sv
// Back end of the WBMP decoder: expands each command into results, one per
// cycle unless stalled, into one output register. Depends on wbmp_sd_pkg.

module wbmp_sd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wbmp_sd_pkg::cmd_t                    head,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [1:0]                           kind,
	output logic [7:0]                           pixel,
	output logic                                 err_code,
	output logic [wbmp_sd_pkg::OUT_DIM_W-1:0]    img_width,
	output logic [wbmp_sd_pkg::OUT_DIM_W-1:0]    img_height,
	output logic                                 last_of_run,
	output logic                                 row_end,
	output logic                                 image_end
);

	logic [2:0] k_q;
	logic       out_valid_q;
	logic       fire;
	logic       is_pix;
	logic       final_res;

	assign is_pix    = (head.kind == wbmp_sd_pkg::KIND_PIXEL);
	assign final_res = !is_pix || (k_q == head.last_idx);
	assign fire      = !q_empty && (!out_valid_q || pop);
	assign q_pop     = fire && final_res;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				k_q         <= final_res ? 3'd0 : k_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload register; the pixel bits go out MSB first.
	always_ff @(posedge clk) begin
		if (fire) begin
			kind        <= head.kind;
			err_code    <= is_pix ? 1'b0 : head.err;
			img_width   <= is_pix ? '0 : head.w;
			img_height  <= is_pix ? '0 : head.h;
			last_of_run <= final_res;
			if (is_pix) begin
				pixel     <= head.data[3'd7 - k_q] ? wbmp_sd_pkg::PIX_WHITE
					: wbmp_sd_pkg::PIX_BLACK;
				row_end   <= final_res && head.rend;
				image_end <= final_res && head.iend;
			end else begin
				pixel     <= wbmp_sd_pkg::PIX_BLACK;
				row_end   <= 1'b0;
				image_end <= 1'b0;
			end
		end
	end

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && is_pix) |-> (k_q <= head.last_idx))
		else $error("pixel index past the final pixel of the byte");

	a_mid_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != 3'd0) |-> !q_empty)
		else $error("command left the queue before all its pixels went out");

endmodule

>>> hdl/wbmp_stream_decoder_top.sv
// Top level of the WBMP type-0 stream decoder: front, command queue, back.
// Depends on wbmp_sd_pkg, wbmp_sd_front, wbmp_sd_cmdq and wbmp_sd_back.
//
// Channel   Handshake          Payload
// input     push / full        in_byte
// result    empty / pop        kind, pixel, err_code, img_width, img_height,
//                              last_of_run, row_end, image_end
//
// One byte is taken per cycle while the command queue has room; a data byte
// then yields up to eight pixel results, one per cycle from the back end
// while the result side keeps popping. A result passes through the command
// queue and then the output register after its byte is taken. Reset is
// asynchronous and leaves the block waiting for the first header byte with
// nothing queued. A stalled result side fills the queue, then raises full.

module wbmp_stream_decoder_top #(
	parameter int DIM_BITS         = wbmp_sd_pkg::DIM_BITS_DEF,
	parameter int MAX_VARINT_BYTES = wbmp_sd_pkg::MAX_VARINT_BYTES_DEF,
	parameter int CMDQ_DEPTH       = wbmp_sd_pkg::CMDQ_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        in_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        kind,
	output logic [7:0]                        pixel,
	output logic                              err_code,
	output logic [wbmp_sd_pkg::OUT_DIM_W-1:0] img_width,
	output logic [wbmp_sd_pkg::OUT_DIM_W-1:0] img_height,
	output logic                              last_of_run,
	output logic                              row_end,
	output logic                              image_end
);

	logic              in_acc;
	logic              cmd_push;
	wbmp_sd_pkg::cmd_t cmd;
	wbmp_sd_pkg::cmd_t head;
	logic              q_empty;
	logic              q_pop;

	assign in_acc = push && !full;

	wbmp_sd_front #(
		.DIM_BITS         (DIM_BITS),
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_byte  (in_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	wbmp_sd_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (cmd),
		.full   (full),
		.pop    (q_pop),
		.rd_cmd (head),
		.empty  (q_empty)
	);

	wbmp_sd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.pixel       (pixel),
		.err_code    (err_code),
		.img_width   (img_width),
		.img_height  (img_height),
		.last_of_run (last_of_run),
		.row_end     (row_end),
		.image_end   (image_end)
	);

endmodule
